/* rtl/wopt_pkg.sv */
// shared types, constants and the cordic angle table for the pose tracker
package wopt_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_LEFT_UPT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_UPT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INV_BASE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_INIT_HEAD = 2'd3;

  localparam logic [23:0] LEFT_UPT_RST = 24'd559241;
  localparam logic [23:0] RIGHT_UPT_RST = 24'd559241;
  localparam logic [23:0] INV_BASE_RST = 24'd1001625;
  localparam logic signed [31:0] INIT_HEAD_RST = 32'sd421657428;

  localparam logic signed [34:0] Q28_PI = 35'sd843314857;
  localparam logic signed [34:0] Q28_TWO_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q28_HALF_PI = 35'sd421657428;
  localparam logic signed [33:0] Q30_GAIN = 34'sd652032874;
  localparam int AtanCount = 28;

  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] x_position;
    logic [31:0] y_position;
    logic [31:0] heading;
    logic [31:0] distance_total;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic signed [31:0] step;
    logic signed [31:0] heading;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_MULC,
    BK_MULS,
    BK_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MULL,
    FR_MULR,
    FR_DIFF,
    FR_MULH,
    FR_HEAD,
    FR_PUSH
  } front_state_t;

  function automatic logic signed [34:0] atan_q28(input logic [4:0] i);
    logic signed [34:0] r;
    case (i)
      5'd0: r = 35'sd210828714;
      5'd1: r = 35'sd124459457;
      5'd2: r = 35'sd65760959;
      5'd3: r = 35'sd33381290;
      5'd4: r = 35'sd16755422;
      5'd5: r = 35'sd8385879;
      5'd6: r = 35'sd4193963;
      5'd7: r = 35'sd2097109;
      5'd8: r = 35'sd1048571;
      5'd9: r = 35'sd524287;
      default: r = (i < 5'd28) ? (35'sd1 <<< (5'd28 - i)) : 35'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/wopt_front.sv */
// front part: encoder deltas, step distance and heading update
module wopt_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  wopt_pkg::in_item_t                in_item,
  input  logic [23:0]                       left_upt,
  input  logic [23:0]                       right_upt,
  input  logic [23:0]                       inv_base,
  input  logic                              head_load,
  input  logic signed [31:0]                head_value,
  output logic                              wvalid,
  input  logic                              wready,
  output wopt_pkg::work_t                   work
);

  wopt_pkg::front_state_t state, state_next;
  logic [31:0] prev_left, prev_right;
  logic signed [31:0] dl, dr;
  logic signed [56:0] wl, wr;
  logic signed [31:0] heading_reg;
  logic signed [31:0] step;
  logic signed [58:0] sum_w, dif_w;
  logic signed [50:0] sum_s;
  logic signed [50:0] dif_s;
  logic signed [39:0] t;
  logic signed [39:0] t_reg;
  logic signed [64:0] tprod;
  logic signed [52:0] dh_raw;
  logic signed [32:0] dh;
  logic signed [32:0] h_sum;
  logic signed [32:0] h_wrap;

  assign full = (state != wopt_pkg::FR_IDLE);
  assign wvalid = (state == wopt_pkg::FR_PUSH);
  assign work.step = step;
  assign work.heading = heading_reg;

  always_comb begin
    sum_w = 59'(wl) + 59'(wr);
    dif_w = 59'(wl) - 59'(wr);
    sum_s = 51'(sum_w >>> 9);
    dif_s = 51'(dif_w >>> 8);
    if (dif_s > 51'sd274877906944) t = 40'sd274877906944;
    else if (dif_s < -51'sd274877906944) t = -40'sd274877906944;
    else t = 40'(dif_s);
    dh_raw = 53'(tprod >>> 12);
    if (dh_raw > 53'(wopt_pkg::Q28_TWO_PI)) dh = 33'(wopt_pkg::Q28_TWO_PI);
    else if (dh_raw < -53'(wopt_pkg::Q28_TWO_PI)) dh = -33'(wopt_pkg::Q28_TWO_PI);
    else dh = 33'(dh_raw);
    h_sum = 33'(heading_reg) + dh;
    if (35'(h_sum) >= wopt_pkg::Q28_TWO_PI) h_wrap = h_sum - 33'(wopt_pkg::Q28_TWO_PI);
    else if (35'(h_sum) < -wopt_pkg::Q28_TWO_PI) h_wrap = h_sum + 33'(wopt_pkg::Q28_TWO_PI);
    else h_wrap = h_sum;
  end

  always_comb begin
    state_next = state;
    case (state)
      wopt_pkg::FR_IDLE: if (push) state_next = wopt_pkg::FR_MULL;
      wopt_pkg::FR_MULL: state_next = wopt_pkg::FR_MULR;
      wopt_pkg::FR_MULR: state_next = wopt_pkg::FR_DIFF;
      wopt_pkg::FR_DIFF: state_next = wopt_pkg::FR_MULH;
      wopt_pkg::FR_MULH: state_next = wopt_pkg::FR_HEAD;
      wopt_pkg::FR_HEAD: state_next = wopt_pkg::FR_PUSH;
      wopt_pkg::FR_PUSH: if (wready) state_next = wopt_pkg::FR_IDLE;
      default: state_next = wopt_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wopt_pkg::FR_IDLE;
      prev_left <= '0;
      prev_right <= '0;
      heading_reg <= wopt_pkg::INIT_HEAD_RST;
    end else begin
      state <= state_next;
      if (head_load) heading_reg <= head_value;
      case (state)
        wopt_pkg::FR_IDLE: if (push) begin
          dl <= $signed(in_item.left_count - prev_left);
          dr <= $signed(in_item.right_count - prev_right);
          prev_left <= in_item.left_count;
          prev_right <= in_item.right_count;
        end
        wopt_pkg::FR_MULL: wl <= dl * $signed({1'b0, left_upt});
        wopt_pkg::FR_MULR: wr <= dr * $signed({1'b0, right_upt});
        wopt_pkg::FR_DIFF: begin
          if (sum_s > 51'sd2147483647) step <= 32'sh7fffffff;
          else if (sum_s < -51'sd2147483648) step <= 32'sh80000000;
          else step <= 32'(sum_s);
          t_reg <= t;
        end
        wopt_pkg::FR_MULH: tprod <= t_reg * $signed({1'b0, inv_base});
        wopt_pkg::FR_HEAD: heading_reg <= 32'(h_wrap);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/wopt_queue.sv */
// two-entry queue between front and back
module wopt_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wvalid,
  output logic                  wready,
  input  wopt_pkg::work_t       wdata,
  output logic                  rvalid,
  input  logic                  rready,
  output wopt_pkg::work_t       rdata
);

  wopt_pkg::work_t mem [2];
  logic wptr, rptr;
  logic [1:0] count;
  logic do_w, do_r;

  assign wready = (count != 2'd2);
  assign rvalid = (count != 2'd0);
  assign rdata = mem[rptr];
  assign do_w = wvalid && wready;
  assign do_r = rvalid && rready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (do_w) begin
        mem[wptr] <= wdata;
        wptr <= ~wptr;
      end
      if (do_r) rptr <= ~rptr;
      count <= count + 2'(do_w) - 2'(do_r);
    end
  end

endmodule

/* rtl/wopt_back.sv */
// back part: serial cordic, position and travel accumulation, result register
module wopt_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rvalid,
  output logic                  rready,
  input  wopt_pkg::work_t       rdata,
  output logic                  empty,
  input  logic                  pop,
  output wopt_pkg::out_item_t   out_item
);

  localparam int Steps = (CORDIC_STEPS < wopt_pkg::AtanCount) ? CORDIC_STEPS
                                                              : wopt_pkg::AtanCount;

  wopt_pkg::back_state_t state, state_next;
  logic [4:0] iter;
  logic signed [33:0] cx, cy;
  logic signed [34:0] cz;
  logic flip;
  logic signed [31:0] step;
  logic signed [31:0] hd;
  logic [31:0] x_reg, y_reg, travel_reg;
  logic signed [65:0] prod;
  logic out_full;
  logic load_out;
  logic signed [34:0] z0, z1;
  logic signed [33:0] xs, ys;
  logic signed [33:0] mul_op;
  logic [32:0] mag;
  logic [33:0] tsum;

  assign empty = !out_full;
  assign rready = (state == wopt_pkg::BK_IDLE);
  assign load_out = (state == wopt_pkg::BK_DONE) && (!out_full || pop);

  always_comb begin
    z0 = 35'(rdata.heading);
    if (z0 >= wopt_pkg::Q28_PI) z0 = z0 - wopt_pkg::Q28_TWO_PI;
    else if (z0 < -wopt_pkg::Q28_PI) z0 = z0 + wopt_pkg::Q28_TWO_PI;
    z1 = z0;
    if (z0 > wopt_pkg::Q28_HALF_PI) z1 = z0 - wopt_pkg::Q28_PI;
    else if (z0 < -wopt_pkg::Q28_HALF_PI) z1 = z0 + wopt_pkg::Q28_PI;
    xs = cx >>> iter;
    ys = cy >>> iter;
    mul_op = (state == wopt_pkg::BK_MULC) ? (flip ? -cx : cx) : (flip ? -cy : cy);
    mag = step[31] ? 33'(-34'(step)) : 33'({1'b0, step});
    tsum = 34'(travel_reg) + 34'(mag);
  end

  always_comb begin
    state_next = state;
    case (state)
      wopt_pkg::BK_IDLE: if (rvalid) state_next = wopt_pkg::BK_ROT;
      wopt_pkg::BK_ROT: if (32'(iter) == Steps - 1) state_next = wopt_pkg::BK_MULC;
      wopt_pkg::BK_MULC: state_next = wopt_pkg::BK_MULS;
      wopt_pkg::BK_MULS: state_next = wopt_pkg::BK_DONE;
      wopt_pkg::BK_DONE: if (!out_full || pop) state_next = wopt_pkg::BK_IDLE;
      default: state_next = wopt_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wopt_pkg::BK_IDLE;
      out_full <= 1'b0;
      x_reg <= '0;
      y_reg <= '0;
      travel_reg <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      case (state)
        wopt_pkg::BK_IDLE: if (rvalid) begin
          cx <= wopt_pkg::Q30_GAIN;
          cy <= '0;
          cz <= z1;
          flip <= (z1 != z0);
          step <= rdata.step;
          hd <= rdata.heading;
          iter <= '0;
        end
        wopt_pkg::BK_ROT: begin
          if (!cz[34]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - wopt_pkg::atan_q28(iter);
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + wopt_pkg::atan_q28(iter);
          end
          iter <= iter + 5'd1;
        end
        wopt_pkg::BK_MULC: prod <= step * mul_op;
        wopt_pkg::BK_MULS: begin
          y_reg <= y_reg + 32'(prod >>> 30);
          prod <= step * mul_op;
        end
        wopt_pkg::BK_DONE: if (load_out) begin
          x_reg <= x_reg + 32'(prod >>> 30);
          travel_reg <= tsum[32] ? 32'hffffffff : tsum[31:0];
          out_item.x_position <= x_reg + 32'(prod >>> 30);
          out_item.y_position <= y_reg;
          out_item.heading <= hd;
          out_item.distance_total <= tsum[32] ? 32'hffffffff : tsum[31:0];
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/wheel_odometry_pose_tracker_unit.sv */
// top level of the differential drive pose tracker
//   channel  handshake      payload
//   input    push / full    in_item (left_count, right_count)
//   result   pop / empty    out_item (x, y, heading, distance_total)
//   config   cfg_we         cfg_index, cfg_data
// an item passes the front states, the queue, the serial cordic loop and the multiply states
// the back takes a new item only after the last one has reached the result register
// the front takes a new item only when idle and runs ahead through a two-entry queue
// synchronous reset loads register defaults and clears pose state
// a waiting result stalls the back only; the front keeps accepting until the queue fills
module wheel_odometry_pose_tracker_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  wopt_pkg::in_item_t                  in_item,
  output logic                                empty,
  input  logic                                pop,
  output wopt_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [wopt_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [wopt_pkg::CfgDataW-1:0]       cfg_data
);

  logic [23:0] left_upt, right_upt, inv_base;
  logic head_load;
  logic wvalid, wready, rvalid, rready;
  wopt_pkg::work_t wdata, rdata;

  assign head_load = cfg_we && (cfg_index == wopt_pkg::REG_INIT_HEAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_upt <= wopt_pkg::LEFT_UPT_RST;
      right_upt <= wopt_pkg::RIGHT_UPT_RST;
      inv_base <= wopt_pkg::INV_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wopt_pkg::REG_LEFT_UPT: left_upt <= cfg_data[23:0];
        wopt_pkg::REG_RIGHT_UPT: right_upt <= cfg_data[23:0];
        wopt_pkg::REG_INV_BASE: inv_base <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  wopt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .left_upt(left_upt), .right_upt(right_upt), .inv_base(inv_base),
    .head_load(head_load), .head_value($signed(cfg_data)),
    .wvalid(wvalid), .wready(wready), .work(wdata)
  );

  wopt_queue u_queue (
    .clk(clk), .rst(rst), .wvalid(wvalid), .wready(wready), .wdata(wdata),
    .rvalid(rvalid), .rready(rready), .rdata(rdata)
  );

  wopt_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .rvalid(rvalid), .rready(rready), .rdata(rdata),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

endmodule
